FILE: sv/handshake_nonce_tracker_macros.svh
// assertion macros shared by the handshake nonce tracker rtl
// no dependencies; pulled in by the files that carry assertions
`ifndef HANDSHAKE_NONCE_TRACKER_MACROS_SVH
`define HANDSHAKE_NONCE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define HNT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen out of reset
`define HNT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define HNT_ASSERT(lbl, clk, rstn, prop, msg)
`define HNT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: sv/hnt_pkg.sv
// shared types and helpers for the handshake nonce tracker
// no dependencies; imported by hnt_state and the top level
`timescale 1ns / 1ps
`default_nettype none

package hnt_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] hnt_word_t;

  typedef enum logic [3:0] {
    CMD_INIT        = 4'd0,
    CMD_CONNECT     = 4'd1,
    CMD_READY       = 4'd2,
    CMD_REQ_SYNC    = 4'd3,
    CMD_TAKE_SYNC   = 4'd4,
    CMD_PREP_SEND   = 4'd5,
    CMD_FINISH_SEND = 4'd6,
    CMD_ACK         = 4'd7,
    CMD_CONSUME     = 4'd8,
    CMD_CLEAR       = 4'd9,
    CMD_SET_FAILED  = 4'd10,
    CMD_STATUS      = 4'd11
  } hnt_cmd_t;

  // one result item
  typedef struct packed {
    logic      failed_out;
    hnt_word_t armed_out;
    hnt_word_t ready_gen_out;
    hnt_word_t current_gen_out;
    hnt_word_t nonce_out;
    logic      ok;
  } hnt_result_t;

  localparam int unsigned RESULT_W   = $bits(hnt_result_t);
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int unsigned IN_FIELD_W = 3 * WORD_W + 1;
  localparam int unsigned IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

  localparam hnt_word_t WORD_ZERO = '0;
  localparam hnt_word_t WORD_ONE  = hnt_word_t'(1);

endpackage

`default_nettype wire

FILE: sv/handshake_nonce_tracker.sv
// handshake nonce tracker: one event in, one result out, two registered stages
// path: an accepted event waits in the input register stage, updates the tracker state as it
// moves into the result register stage, and out_tvalid is driven from the result register
// throughput: one event per cycle; while a result waits both stages hold and input
// stalls once the event stage is full
// reset: rst_n synchronous active low; generations, nonces, sync and failed flag
// clear, nonce counter starts at one, both stages empty
`timescale 1ns / 1ps
`default_nettype none

module handshake_nonce_tracker
  import hnt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // generation, nonce, seed, failed_flag, zero pad
  input  wire logic [3:0]            in_tuser,   // cmd
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // ok, nonce_out, current_gen_out,
                                                 // ready_gen_out, armed_out, failed_out, zero pad
);

  // input register stage
  logic      in_valid_r;
  hnt_cmd_t  cmd_r;
  hnt_word_t gen_r;
  hnt_word_t nonce_r;
  hnt_word_t seed_r;
  logic      flag_r;

  // result register stage
  logic        out_valid_r;
  hnt_result_t out_res_r;

  hnt_result_t res;
  logic        advance;  // event stage may hand its item to the result register
  logic        step_en;  // event applied to the tracker state this cycle

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  // input stage frees up whenever its item moves on
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= hnt_cmd_t'(in_tuser);
      gen_r   <= in_tdata[WORD_W-1:0];
      nonce_r <= in_tdata[2*WORD_W-1:WORD_W];
      seed_r  <= in_tdata[3*WORD_W-1:2*WORD_W];
      flag_r  <= in_tdata[3*WORD_W];
    end
  end

  // state registers and event logic
  hnt_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .cmd         (cmd_r),
    .generation  (gen_r),
    .nonce       (nonce_r),
    .seed        (seed_r),
    .failed_flag (flag_r),
    .res         (res)
  );

  // result register: loads when the event stage advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res_r};

endmodule

`default_nettype wire

FILE: sv/hnt_state.sv
// tracker state registers and the combinational event logic
// depends on hnt_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "handshake_nonce_tracker_macros.svh"

module hnt_state
  import hnt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire hnt_cmd_t    cmd,
  input  wire hnt_word_t   generation,
  input  wire hnt_word_t   nonce,
  input  wire hnt_word_t   seed,
  input  wire logic        failed_flag,
  output hnt_result_t      res
);

  hnt_word_t cur_r, cur_nxt;
  hnt_word_t rdy_r, rdy_nxt;
  hnt_word_t armed_r, armed_nxt;
  hnt_word_t pend_r, pend_nxt;
  hnt_word_t cnt_r, cnt_nxt;
  hnt_word_t sync_r, sync_nxt;
  logic      failed_r, failed_nxt;

  logic      gen_nz, nonce_nz;
  logic      cur_live;  // current generation is ready
  logic      gen_live;  // named generation is current and ready
  hnt_word_t cnt_inc, alloc;

  assign gen_nz   = (generation != WORD_ZERO);
  assign nonce_nz = (nonce != WORD_ZERO);
  assign cur_live = (cur_r != WORD_ZERO) && (rdy_r == cur_r);
  assign gen_live = gen_nz && (cur_r == generation) && (rdy_r == generation);
  assign cnt_inc  = cnt_r + WORD_ONE;
  // skip zero on wrap
  assign alloc    = (cnt_inc == WORD_ZERO) ? WORD_ONE : cnt_inc;

  always_comb begin
    cur_nxt    = cur_r;
    rdy_nxt    = rdy_r;
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    sync_nxt   = sync_r;
    failed_nxt = failed_r;
    res.ok        = 1'b0;
    res.nonce_out = WORD_ZERO;
    case (cmd)
      CMD_INIT: begin
        cur_nxt    = WORD_ZERO;
        rdy_nxt    = WORD_ZERO;
        armed_nxt  = WORD_ZERO;
        pend_nxt   = WORD_ZERO;
        cnt_nxt    = (seed == WORD_ZERO) ? WORD_ONE : seed;
        sync_nxt   = WORD_ZERO;
        failed_nxt = 1'b0;
      end
      CMD_CONNECT: begin
        if (gen_nz) begin
          cur_nxt   = generation;
          rdy_nxt   = WORD_ZERO;
          armed_nxt = WORD_ZERO;
          pend_nxt  = WORD_ZERO;
          sync_nxt  = WORD_ZERO;
        end
      end
      CMD_READY: begin
        if (gen_nz && (cur_r == generation)) begin
          rdy_nxt = generation;
        end
      end
      CMD_REQ_SYNC: begin
        if (cur_live) begin
          sync_nxt = cur_r;
          res.ok   = 1'b1;
        end
      end
      CMD_TAKE_SYNC: begin
        if (gen_nz && (sync_r == generation)) begin
          sync_nxt = WORD_ZERO;
          res.ok   = gen_live;
        end
      end
      CMD_PREP_SEND: begin
        if (gen_live) begin
          cnt_nxt       = alloc;
          res.nonce_out = alloc;
          pend_nxt      = WORD_ZERO;
          armed_nxt     = alloc;
          res.ok        = 1'b1;
        end
      end
      CMD_FINISH_SEND: begin
        if (gen_nz && nonce_nz) begin
          if (gen_live && (armed_r == nonce)) begin
            res.ok = 1'b1;
          end else begin
            if (armed_r == nonce) armed_nxt = WORD_ZERO;
            if (pend_r == nonce) pend_nxt = WORD_ZERO;
          end
        end
      end
      CMD_ACK: begin
        if (nonce_nz && cur_live && (armed_r == nonce)) begin
          pend_nxt = nonce;
          res.ok   = 1'b1;
        end
      end
      CMD_CONSUME: begin
        if (gen_nz && nonce_nz && (pend_r == nonce)) begin
          pend_nxt = WORD_ZERO;
          res.ok   = gen_live && (armed_r == nonce);
        end
      end
      CMD_CLEAR: begin
        if (nonce_nz) begin
          if (armed_r == nonce) armed_nxt = WORD_ZERO;
          if (pend_r == nonce) pend_nxt = WORD_ZERO;
        end
      end
      CMD_SET_FAILED: begin
        failed_nxt = failed_flag;
      end
      CMD_STATUS: begin
        res.ok = failed_r;
      end
      default: begin
      end
    endcase
    res.current_gen_out = cur_nxt;
    res.ready_gen_out   = ((cur_nxt != WORD_ZERO) && (rdy_nxt == cur_nxt)) ? cur_nxt : WORD_ZERO;
    res.armed_out       = armed_nxt;
    res.failed_out      = failed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= WORD_ZERO;
      rdy_r    <= WORD_ZERO;
      armed_r  <= WORD_ZERO;
      pend_r   <= WORD_ZERO;
      cnt_r    <= WORD_ONE;
      sync_r   <= WORD_ZERO;
      failed_r <= 1'b0;
    end else if (step_en) begin
      cur_r    <= cur_nxt;
      rdy_r    <= rdy_nxt;
      armed_r  <= armed_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      sync_r   <= sync_nxt;
      failed_r <= failed_nxt;
    end
  end

  `HNT_ASSERT_NEVER(a_cnt_zero, clk, rst_n, cnt_r == WORD_ZERO, "nonce counter reached zero")
  `HNT_ASSERT(a_alloc_armed, clk, rst_n, step_en && (res.nonce_out != WORD_ZERO) |=> armed_r == $past(res.nonce_out), "allocated nonce not armed")
  `HNT_ASSERT(a_alloc_only_prep, clk, rst_n, step_en && (res.nonce_out != WORD_ZERO) |-> (cmd == CMD_PREP_SEND) && res.ok, "nonce handed out outside prepare send")
  `HNT_ASSERT(a_connect_clears, clk, rst_n, step_en && (cmd == CMD_CONNECT) && gen_nz |=> (armed_r == WORD_ZERO) && (pend_r == WORD_ZERO) && (sync_r == WORD_ZERO), "connect left stale nonce state")

endmodule

`default_nettype wire

FILE: sim/handshake_nonce_tracker_tb.sv
// testbench for the handshake nonce tracker: streams single events and checks each result
// against a cycle-free model of the tracker state; depends on hnt_pkg and the rtl top level
`timescale 1ns / 1ps

module handshake_nonce_tracker_tb;
  import hnt_pkg::*;

  // command codes outside the defined set, the block must ignore them
  localparam logic [3:0] CMD_UNUSED_LO = 4'd12;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // tracker state model plus the queue of results still owed by the block
  class nonce_tracker_scoreboard;
    hnt_word_t   cur_gen;
    hnt_word_t   rdy_gen;
    hnt_word_t   armed;
    hnt_word_t   pending;
    hnt_word_t   counter;
    hnt_word_t   sync_req;
    logic        failed;
    hnt_result_t expected_results[$];
    int unsigned errors;

    function new();
      cur_gen      = WORD_ZERO;
      rdy_gen      = WORD_ZERO;
      armed        = WORD_ZERO;
      pending      = WORD_ZERO;
      counter      = WORD_ONE;
      sync_req     = WORD_ZERO;
      failed       = 1'b0;
      errors       = 0;
    endfunction

    // current generation when it has reported ready
    function hnt_word_t live_ready();
      return (cur_gen != WORD_ZERO && rdy_gen == cur_gen) ? cur_gen : WORD_ZERO;
    endfunction

    function bit gen_live(hnt_word_t g);
      return g != WORD_ZERO && cur_gen == g && live_ready() == g;
    endfunction

    function void drop_nonce(hnt_word_t n);
      if (n == WORD_ZERO) return;
      if (armed == n) armed = WORD_ZERO;
      if (pending == n) pending = WORD_ZERO;
    endfunction

    // apply one accepted event and queue the result it must produce
    function void note_event(logic [3:0] cmd, hnt_word_t gen, hnt_word_t nonce,
                             hnt_word_t seed, logic flag);
      hnt_result_t r;
      r = '0;
      case (cmd)
        CMD_INIT: begin
          cur_gen  = WORD_ZERO;
          rdy_gen  = WORD_ZERO;
          armed    = WORD_ZERO;
          pending  = WORD_ZERO;
          counter  = (seed == WORD_ZERO) ? WORD_ONE : seed;
          sync_req = WORD_ZERO;
          failed   = 1'b0;
        end
        CMD_CONNECT: begin
          if (gen != WORD_ZERO) begin
            cur_gen  = gen;
            rdy_gen  = WORD_ZERO;
            armed    = WORD_ZERO;
            pending  = WORD_ZERO;
            sync_req = WORD_ZERO;
          end
        end
        CMD_READY: begin
          if (gen != WORD_ZERO && cur_gen == gen) rdy_gen = gen;
        end
        CMD_REQ_SYNC: begin
          if (gen_live(cur_gen)) begin
            sync_req = cur_gen;
            r.ok     = 1'b1;
          end
        end
        CMD_TAKE_SYNC: begin
          if (gen != WORD_ZERO && sync_req == gen) begin
            sync_req = WORD_ZERO;
            r.ok     = gen_live(gen);
          end
        end
        CMD_PREP_SEND: begin
          if (gen_live(gen)) begin
            counter = counter + WORD_ONE;
            if (counter == WORD_ZERO) counter = counter + WORD_ONE;
            r.nonce_out = counter;
            pending     = WORD_ZERO;
            armed       = counter;
            r.ok        = 1'b1;
          end
        end
        CMD_FINISH_SEND: begin
          if (gen != WORD_ZERO && nonce != WORD_ZERO) begin
            if (gen_live(gen) && armed == nonce) r.ok = 1'b1;
            else drop_nonce(nonce);
          end
        end
        CMD_ACK: begin
          if (nonce != WORD_ZERO && gen_live(cur_gen) && armed == nonce) begin
            pending = nonce;
            r.ok    = 1'b1;
          end
        end
        CMD_CONSUME: begin
          if (gen != WORD_ZERO && nonce != WORD_ZERO && pending == nonce) begin
            pending = WORD_ZERO;
            r.ok    = gen_live(gen) && armed == nonce;
          end
        end
        CMD_CLEAR:      drop_nonce(nonce);
        CMD_SET_FAILED: failed = flag;
        CMD_STATUS:     r.ok = failed;
        default: ;
      endcase
      r.current_gen_out = cur_gen;
      r.ready_gen_out   = live_ready();
      r.armed_out       = armed;
      r.failed_out      = failed;
      expected_results.push_back(r);
    endfunction

    function void report(string what, hnt_word_t exp_v, hnt_word_t act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
    endfunction

    function void field_check(string what, hnt_word_t exp_v, hnt_word_t act_v);
      if (exp_v !== act_v) report(what, exp_v, act_v);
    endfunction

    // compare one result transfer with the oldest owed result
    function void check_result(hnt_result_t got);
      hnt_result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result", WORD_ZERO, got.current_gen_out);
        return;
      end
      want = expected_results.pop_front();
      field_check("ok", hnt_word_t'(want.ok), hnt_word_t'(got.ok));
      field_check("nonce_out", want.nonce_out, got.nonce_out);
      field_check("current_gen_out", want.current_gen_out, got.current_gen_out);
      field_check("ready_gen_out", want.ready_gen_out, got.ready_gen_out);
      field_check("armed_out", want.armed_out, got.armed_out);
      field_check("failed_out", hnt_word_t'(want.failed_out), hnt_word_t'(got.failed_out));
    endfunction
  endclass

  // clock and block ports, all inputs known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // generation, nonce, seed, failed_flag, zero pad
  logic [3:0]            in_tuser   = '0;   // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // ok, nonce_out, current_gen_out,
                                            // ready_gen_out, armed_out, failed_out, zero pad

  nonce_tracker_scoreboard sb = new();

  // number of events accepted so far, and a window where neither side idles
  int unsigned item_count = 0;
  bit          no_idle    = 1'b0;

  handshake_nonce_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random back-pressure and checking of every result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(hnt_result_t'(out_tdata[RESULT_W-1:0]));
      end
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  function automatic hnt_word_t rand_word();
    return hnt_word_t'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // mostly the live generation, sometimes zero or a stray value
  function automatic hnt_word_t pick_gen();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return sb.cur_gen;
    if (roll < 88) return WORD_ZERO;
    return rand_word();
  endfunction

  // mostly the armed or pending nonce so that acks and consumes can succeed
  function automatic hnt_word_t pick_nonce();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return sb.armed;
    if (roll < 75) return sb.pending;
    if (roll < 83) return WORD_ZERO;
    return rand_word();
  endfunction

  // zero, near the wrap point, or anything
  function automatic hnt_word_t pick_seed();
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll == 0) return WORD_ZERO;
    if (roll == 1) return ~hnt_word_t'($urandom_range(3));
    return rand_word();
  endfunction

  // one event transfer on the input side; called at a rising edge, returns at one
  task automatic send_event(logic [3:0] cmd, hnt_word_t gen, hnt_word_t nonce,
                            hnt_word_t seed, logic flag);
    int unsigned gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 35) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({flag, seed, nonce, gen});
    do @(posedge clk); while (!in_tready);
    sb.note_event(cmd, gen, nonce, seed, flag);
    item_count++;
    no_idle = (item_count >= 450 && item_count < 650);
  endtask

  // a connect, ready and send round trip with mostly coherent content
  task automatic run_session();
    hnt_word_t   g;
    int unsigned rounds;
    if ($urandom_range(9) == 0)
      send_event(CMD_INIT, rand_word(), rand_word(), pick_seed(), rand_bit());
    g = ($urandom_range(3) == 0) ? hnt_word_t'($urandom_range(4)) : rand_word();
    send_event(CMD_CONNECT, g, rand_word(), rand_word(), rand_bit());
    send_event(CMD_READY, ($urandom_range(9) == 0) ? rand_word() : g,
               rand_word(), rand_word(), rand_bit());
    if ($urandom_range(1)) begin
      send_event(CMD_REQ_SYNC, rand_word(), rand_word(), rand_word(), rand_bit());
      send_event(CMD_TAKE_SYNC, pick_gen(), rand_word(), rand_word(), rand_bit());
    end
    rounds = $urandom_range(4, 1);
    repeat (rounds) begin
      send_event(CMD_PREP_SEND, pick_gen(), rand_word(), rand_word(), rand_bit());
      send_event(CMD_FINISH_SEND, pick_gen(), pick_nonce(), rand_word(), rand_bit());
      send_event(CMD_ACK, rand_word(), pick_nonce(), rand_word(), rand_bit());
      send_event(CMD_CONSUME, pick_gen(), pick_nonce(), rand_word(), rand_bit());
      case ($urandom_range(5))
        0: send_event(CMD_CLEAR, rand_word(), pick_nonce(), rand_word(), rand_bit());
        1: send_event(CMD_SET_FAILED, rand_word(), rand_word(), rand_word(), rand_bit());
        2: send_event(CMD_STATUS, rand_word(), rand_word(), rand_word(), rand_bit());
        3: send_event(CMD_REQ_SYNC, rand_word(), rand_word(), rand_word(), rand_bit());
        default: ;
      endcase
    end
  endtask

  initial begin
    hnt_word_t top_gen;
    top_gen = ~WORD_ZERO;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state and zero generation / nonce handling
    send_event(CMD_STATUS, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_PREP_SEND, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_CONNECT, WORD_ZERO, top_gen, top_gen, 1'b1);
    send_event(CMD_INIT, top_gen, top_gen, WORD_ZERO, 1'b1);
    send_event(CMD_CONNECT, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    // stale ready is ignored, sync refused before ready
    send_event(CMD_READY, hnt_word_t'(5), WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_REQ_SYNC, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_READY, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_REQ_SYNC, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_TAKE_SYNC, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_TAKE_SYNC, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    // full send, ack and consume on the live generation
    send_event(CMD_PREP_SEND, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_FINISH_SEND, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_FINISH_SEND, top_gen, sb.armed, WORD_ZERO, 1'b0);
    send_event(CMD_ACK, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_ACK, WORD_ZERO, sb.armed, WORD_ZERO, 1'b0);
    send_event(CMD_CONSUME, WORD_ZERO, sb.armed, WORD_ZERO, 1'b0);
    send_event(CMD_CONSUME, top_gen, sb.armed, WORD_ZERO, 1'b0);
    // a finish on the wrong generation drops the armed nonce
    send_event(CMD_PREP_SEND, top_gen, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_FINISH_SEND, hnt_word_t'(7), sb.armed, WORD_ZERO, 1'b0);
    send_event(CMD_CLEAR, top_gen, WORD_ZERO, top_gen, 1'b1);
    // failed flag and unused command codes
    send_event(CMD_SET_FAILED, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b1);
    send_event(CMD_STATUS, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_UNUSED_LO, top_gen, top_gen, top_gen, 1'b0);
    send_event(CMD_UNUSED_HI, top_gen, top_gen, top_gen, 1'b1);
    send_event(CMD_SET_FAILED, WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0);
    // counter wrap: all-ones seed, next allocation skips zero
    send_event(CMD_INIT, WORD_ZERO, WORD_ZERO, top_gen, 1'b0);
    send_event(CMD_CONNECT, WORD_ONE, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_READY, WORD_ONE, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_PREP_SEND, WORD_ONE, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_PREP_SEND, WORD_ONE, WORD_ZERO, WORD_ZERO, 1'b0);
    send_event(CMD_CLEAR, WORD_ZERO, sb.armed, WORD_ZERO, 1'b0);

    // random part: mostly coherent sessions, the rest single noise events
    while (item_count < 1040) begin
      if ($urandom_range(99) < 70) begin
        run_session();
      end else begin
        repeat ($urandom_range(3, 1))
          send_event(4'($urandom_range(15)), rand_word(), rand_word(), rand_word(),
                     rand_bit());
      end
    end
    in_tvalid <= 1'b0;

    // drain owed results, then keep watching the result side to catch anything extra
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
